@@ sv/prot_pkg.sv @@
// shared widths, payload types and arctangent table for the point rotation pipeline
package prot_pkg;

	// field widths
	localparam int COORD_WIDTH = 16;
	localparam int ANGLE_WIDTH = 16;

	// datapath sizing
	localparam int GUARD_BITS = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 2;
	localparam int ANGLE_FRAC = 32;
	localparam int GAIN_SHIFT = 30 - GUARD_BITS;

	// gain compensation 0.60725..., Q30
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	// atan(2^-i) as a Q32 fraction of a turn
	localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1
	};

	// input item
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic [ANGLE_WIDTH-1:0] turn_angle;
		logic last_point;
	} point_t;

	// result item
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rotated_x;
		logic signed [COORD_WIDTH-1:0] rotated_y;
		logic last_out;
	} result_t;

endpackage

@@ sv/point_rotate_unit.sv @@
// point rotation pipeline: quadrant fold, gain multiply, unrolled cordic stages, rounding
//
// Rotates each incoming point counter-clockwise by its own angle, given as a fraction
// of a full turn, and returns the rotated point in the same Q12.4 format, saturated.
// The last_point flag rides along unchanged as last_out.
//
// Channels: point (input) and result (output), each a valid/stall pair with a packed
// struct payload. A transfer happens on a rising edge with valid high and stall low.
//
// Pipeline: 18 register stages from a point transfer to its result: one for the
// quadrant fold, one for the gain multiply, fifteen cordic stages of two
// micro-rotations each, and one for rounding and saturation into the output register.
// Throughput: one point per cycle; points are independent, so nothing limits the
// rate but the output side.
//
// Stall: when the output register holds a result and result_stall is high, the whole
// pipeline holds and point_stall is raised; nothing is dropped or repeated.
// Reset: arst_n clears every stage valid bit; the pipeline comes up empty.
module point_rotate_unit (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	output logic point_stall,
	input prot_pkg::point_t point,
	output logic result_valid,
	input logic result_stall,
	output prot_pkg::result_t result
);

	localparam int CW = prot_pkg::COORD_WIDTH;
	localparam int AW = prot_pkg::ANGLE_WIDTH;
	localparam int DW = prot_pkg::DATA_WIDTH;
	localparam int GB = prot_pkg::GUARD_BITS;
	localparam int NS = prot_pkg::CORDIC_STAGES;
	localparam int SPS = prot_pkg::STEPS_PER_STAGE;
	localparam int ZW = prot_pkg::ANGLE_FRAC;
	localparam int PW = CW + 33;
	localparam int RW = DW + 1;
	localparam int OW = RW - GB;
	localparam logic [AW-1:0] EIGHTH = AW'(1) << (AW - 3);
	localparam logic signed [RW-1:0] HALF_LSB = RW'(1) << (GB - 1);
	localparam logic signed [OW-1:0] SAT_HI = OW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

	logic adv;

	// stage 1: quadrant fold
	logic vld_s1;
	logic last_s1;
	logic signed [CW:0] x_s1;
	logic signed [CW:0] y_s1;
	logic signed [ZW-1:0] z_s1;

	logic [AW-1:0] angle_bias;
	logic [1:0] quad;
	logic [AW-1:0] resid;
	logic signed [CW:0] px;
	logic signed [CW:0] py;
	logic signed [CW:0] fold_x;
	logic signed [CW:0] fold_y;

	// cordic stage registers, index 0 is stage 2 (after the gain multiply)
	logic vld_s [NS+1];
	logic last_s [NS+1];
	logic signed [DW-1:0] cx_s [NS+1];
	logic signed [DW-1:0] cy_s [NS+1];
	logic signed [ZW-1:0] cz_s [NS+1];

	logic signed [PW-1:0] prod_x;
	logic signed [PW-1:0] prod_y;

	// output stage
	logic vld_s18;
	prot_pkg::result_t res_s18;
	logic signed [RW-1:0] round_x;
	logic signed [RW-1:0] round_y;
	logic signed [OW-1:0] trunc_x;
	logic signed [OW-1:0] trunc_y;

	// whole pipeline moves unless a finished result is held back
	assign adv = !(vld_s18 && result_stall);
	assign point_stall = !adv;

	// fold the angle into [-1/8, 1/8) turn and turn the point by whole quarters
	always_comb begin
		angle_bias = point.turn_angle + EIGHTH;
		quad = angle_bias[AW-1:AW-2];
		resid = point.turn_angle - {quad, {(AW-2){1'b0}}};
		px = (CW+1)'(point.point_x);
		py = (CW+1)'(point.point_y);
		unique case (quad)
			2'd1: begin
				fold_x = -py;
				fold_y = px;
			end
			2'd2: begin
				fold_x = -px;
				fold_y = -py;
			end
			2'd3: begin
				fold_x = py;
				fold_y = -px;
			end
			default: begin
				fold_x = px;
				fold_y = py;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= point_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= point.last_point;
			x_s1 <= fold_x;
			y_s1 <= fold_y;
			z_s1 <= {resid, {(ZW-AW){1'b0}}};
		end
	end

	// stage 2: gain compensation, leaves guard fraction bits below Q12.4
	assign prod_x = PW'(x_s1) * PW'(prot_pkg::GAIN_Q30);
	assign prod_y = PW'(y_s1) * PW'(prot_pkg::GAIN_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s[0] <= last_s1;
			cx_s[0] <= prod_x[DW+prot_pkg::GAIN_SHIFT-1:prot_pkg::GAIN_SHIFT];
			cy_s[0] <= prod_y[DW+prot_pkg::GAIN_SHIFT-1:prot_pkg::GAIN_SHIFT];
			cz_s[0] <= z_s1;
		end
	end

	// cordic stages, two micro-rotations each
	for (genvar k = 0; k < NS; k++) begin : g_cordic
		localparam int I0 = SPS * k;
		localparam int I1 = SPS * k + 1;
		logic signed [DW-1:0] xa;
		logic signed [DW-1:0] ya;
		logic signed [ZW-1:0] za;
		logic signed [DW-1:0] xb;
		logic signed [DW-1:0] yb;
		logic signed [ZW-1:0] zb;

		always_comb begin
			if (!cz_s[k][ZW-1]) begin
				xa = cx_s[k] - (cy_s[k] >>> I0);
				ya = cy_s[k] + (cx_s[k] >>> I0);
				za = cz_s[k] - prot_pkg::ATAN_TURN[I0];
			end else begin
				xa = cx_s[k] + (cy_s[k] >>> I0);
				ya = cy_s[k] - (cx_s[k] >>> I0);
				za = cz_s[k] + prot_pkg::ATAN_TURN[I0];
			end
			if (!za[ZW-1]) begin
				xb = xa - (ya >>> I1);
				yb = ya + (xa >>> I1);
				zb = za - prot_pkg::ATAN_TURN[I1];
			end else begin
				xb = xa + (ya >>> I1);
				yb = ya - (xa >>> I1);
				zb = za + prot_pkg::ATAN_TURN[I1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				last_s[k+1] <= last_s[k];
				cx_s[k+1] <= xb;
				cy_s[k+1] <= yb;
				cz_s[k+1] <= zb;
			end
		end
	end

	// round half up, drop guard bits, saturate to the coordinate range
	assign round_x = RW'(cx_s[NS]) + HALF_LSB;
	assign round_y = RW'(cy_s[NS]) + HALF_LSB;
	assign trunc_x = round_x[RW-1:GB];
	assign trunc_y = round_y[RW-1:GB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
		end else if (adv) begin
			vld_s18 <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s18.last_out <= last_s[NS];
			priority if (trunc_x > SAT_HI) begin
				res_s18.rotated_x <= SAT_HI[CW-1:0];
			end else if (trunc_x < SAT_LO) begin
				res_s18.rotated_x <= SAT_LO[CW-1:0];
			end else begin
				res_s18.rotated_x <= trunc_x[CW-1:0];
			end
			priority if (trunc_y > SAT_HI) begin
				res_s18.rotated_y <= SAT_HI[CW-1:0];
			end else if (trunc_y < SAT_LO) begin
				res_s18.rotated_y <= SAT_LO[CW-1:0];
			end else begin
				res_s18.rotated_y <= trunc_y[CW-1:0];
			end
		end
	end

	assign result_valid = vld_s18;
	assign result = res_s18;

endmodule

@@ sim/rotation_checker.sv @@
// transfer monitor for the point rotation pipeline: predicts each rotated point and compares
module rotation_checker (
	input logic clk,
	input logic arst_n,
	input logic point_valid,
	input logic point_stall,
	input prot_pkg::point_t point,
	input logic result_valid,
	input logic result_stall,
	input prot_pkg::result_t result,
	output int error_count,
	output int pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_WIDTH = prot_pkg::COORD_WIDTH;
	localparam int ANGLE_WIDTH = prot_pkg::ANGLE_WIDTH;

	// rotation arithmetic: guard fraction bits, micro-rotations, Q30 gain 0.60725...
	localparam int FRAC_GUARD = 16;
	localparam int ROTATION_STEPS = 30;
	localparam longint GAIN_FACTOR = 64'sd652032874;

	prot_pkg::result_t rotated_queue [$];
	int faults;

	// arctangent of 2^-i as a Q32 fraction of a turn
	function automatic longint step_angle(int i);
		unique case (i)
			0: return 536870912;
			1: return 316933406;
			2: return 167458907;
			3: return 85004756;
			4: return 42667331;
			5: return 21354465;
			6: return 10679838;
			7: return 5340245;
			8: return 2670163;
			9: return 1335087;
			10: return 667544;
			11: return 333772;
			12: return 166886;
			13: return 83443;
			14: return 41722;
			15: return 20861;
			16: return 10430;
			17: return 5215;
			18: return 2608;
			19: return 1304;
			20: return 652;
			21: return 326;
			22: return 163;
			23: return 81;
			24: return 41;
			25: return 20;
			26: return 10;
			27: return 5;
			28: return 3;
			default: return 1;
		endcase
	endfunction

	// expected rotated point: quarter-turn fold, gain, cordic, round and saturate
	function automatic prot_pkg::result_t rotate_point(prot_pkg::point_t p);
		logic [ANGLE_WIDTH-1:0] biased;
		logic [1:0] quadrant;
		logic [ANGLE_WIDTH-1:0] residual;
		longint px, py, x, y, z, dx, dy, lim;
		prot_pkg::result_t r;
		biased = p.turn_angle + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 3));
		quadrant = biased[ANGLE_WIDTH-1 -: 2];
		residual = p.turn_angle - {quadrant, {(ANGLE_WIDTH-2){1'b0}}};
		z = longint'($signed(residual)) * (longint'(1) << (32 - ANGLE_WIDTH));
		px = longint'($signed(p.point_x));
		py = longint'($signed(p.point_y));
		unique case (quadrant)
			2'd1: begin
				x = -py;
				y = px;
			end
			2'd2: begin
				x = -px;
				y = -py;
			end
			2'd3: begin
				x = py;
				y = -px;
			end
			default: begin
				x = px;
				y = py;
			end
		endcase
		x = (x * GAIN_FACTOR) >>> (30 - FRAC_GUARD);
		y = (y * GAIN_FACTOR) >>> (30 - FRAC_GUARD);
		// both updates of a step use the old x and y
		for (int i = 0; i < ROTATION_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= step_angle(i);
			end else begin
				x += dx;
				y -= dy;
				z += step_angle(i);
			end
		end
		// round half up, then clamp to the coordinate range
		x = (x + (longint'(1) << (FRAC_GUARD - 1))) >>> FRAC_GUARD;
		y = (y + (longint'(1) << (FRAC_GUARD - 1))) >>> FRAC_GUARD;
		lim = (longint'(1) << (COORD_WIDTH - 1)) - 1;
		if (x > lim) x = lim;
		else if (x < -lim - 1) x = -lim - 1;
		if (y > lim) y = lim;
		else if (y < -lim - 1) y = -lim - 1;
		r.rotated_x = COORD_WIDTH'(x);
		r.rotated_y = COORD_WIDTH'(y);
		r.last_out = p.last_point;
		return r;
	endfunction

	// compare each result transfer with the oldest prediction, queue new predictions
	always @(posedge clk or negedge arst_n) begin
		prot_pkg::result_t want;
		if (!arst_n) begin
			rotated_queue.delete();
			faults = 0;
			error_count <= 0;
			pending_count <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (rotated_queue.size() == 0) begin
					faults++;
					$display("%0t: unexpected result, expected none, got x=%0d y=%0d last=%0b",
						$time, result.rotated_x, result.rotated_y, result.last_out);
				end else begin
					want = rotated_queue.pop_front();
					if (result.rotated_x !== want.rotated_x) begin
						faults++;
						$display("%0t: rotated_x mismatch, expected %0d, got %0d",
							$time, want.rotated_x, result.rotated_x);
					end
					if (result.rotated_y !== want.rotated_y) begin
						faults++;
						$display("%0t: rotated_y mismatch, expected %0d, got %0d",
							$time, want.rotated_y, result.rotated_y);
					end
					if (result.last_out !== want.last_out) begin
						faults++;
						$display("%0t: last_out mismatch, expected %0b, got %0b",
							$time, want.last_out, result.last_out);
					end
				end
			end
			if (point_valid && !point_stall)
				rotated_queue = {rotated_queue, rotate_point(point)};
			pending_count <= rotated_queue.size();
			error_count <= faults;
		end
	end

endmodule

@@ sim/testbench.sv @@
// top of the point rotation testbench: clock, reset, point stimulus, result stalls, verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_WIDTH = prot_pkg::COORD_WIDTH;
	localparam int ANGLE_WIDTH = prot_pkg::ANGLE_WIDTH;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_POINTS = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	prot_pkg::point_t point = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	prot_pkg::result_t result;
	int error_count;
	int pending_count;
	int idle_cycles = 0;
	bit send_burst = 1'b0;

	point_rotate_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	rotation_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.error_count(error_count),
		.pending_count(pending_count)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((point_valid && !point_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side: random stall before each transfer, with stretches of none
	initial begin
		int hold;
		logic taken;
		bit drain_burst;
		drain_burst = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				drain_burst = ~drain_burst;
			hold = drain_burst ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do begin
				@(negedge clk);
				taken = result_valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	function automatic prot_pkg::point_t make_point(int x, int y, int a, bit last);
		prot_pkg::point_t p;
		p.point_x = COORD_WIDTH'(x);
		p.point_y = COORD_WIDTH'(y);
		p.turn_angle = ANGLE_WIDTH'(a);
		p.last_point = last;
		return p;
	endfunction

	// coordinates: range ends, small values, or anything
	function automatic logic [COORD_WIDTH-1:0] draw_coord();
		unique case ($urandom_range(0, 5))
			0: begin
				unique case ($urandom_range(0, 4))
					0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
					1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
					2: return '0;
					3: return '1;
					default: return COORD_WIDTH'(1);
				endcase
			end
			1, 2: return COORD_WIDTH'($urandom_range(0, 4000)) - COORD_WIDTH'(2000);
			default: return COORD_WIDTH'($urandom);
		endcase
	endfunction

	// angles: eighth turns, near the quadrant fold edges, or anything
	function automatic logic [ANGLE_WIDTH-1:0] draw_angle();
		unique case ($urandom_range(0, 3))
			0: return ANGLE_WIDTH'($urandom_range(0, 7)) << (ANGLE_WIDTH - 3);
			1: return (ANGLE_WIDTH'($urandom_range(0, 7)) << (ANGLE_WIDTH - 3))
				+ ANGLE_WIDTH'($urandom_range(0, 4)) - ANGLE_WIDTH'(2);
			default: return ANGLE_WIDTH'($urandom);
		endcase
	endfunction

	// one point transfer after a random gap, payload held while stalled
	task automatic send_point(input prot_pkg::point_t p);
		int gap;
		logic taken;
		gap = send_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		do begin
			@(negedge clk);
			taken = !point_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// stop sending until every predicted result has come out
	task automatic hold_until_drained();
		point_valid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		prot_pkg::point_t p;
		int sent;
		int path_len;
		logic [ANGLE_WIDTH-1:0] path_angle;
		bit shared_angle;
		bit noise;
		bit paused_mid;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: range ends, quarter turns, fold boundaries, saturation
		send_point(make_point(0, 0, 0, 0));
		send_point(make_point(16, 0, 0, 0));
		send_point(make_point(16, 0, 16384, 0));
		send_point(make_point(16, 0, 32768, 0));
		send_point(make_point(16, 0, 49152, 1));
		send_point(make_point(32767, 32767, 0, 0));
		send_point(make_point(-32768, -32768, 0, 0));
		send_point(make_point(-32768, -32768, 32768, 0));
		send_point(make_point(-32768, 0, 16384, 0));
		send_point(make_point(32767, 32767, 8192, 0));
		send_point(make_point(-32768, 32767, 24576, 0));
		send_point(make_point(1000, -2000, 8191, 0));
		send_point(make_point(1000, -2000, 8192, 0));
		send_point(make_point(1000, -2000, 24575, 0));
		send_point(make_point(1000, -2000, 40959, 0));
		send_point(make_point(1000, -2000, 40960, 0));
		send_point(make_point(1000, -2000, 57343, 0));
		send_point(make_point(1000, -2000, 57344, 0));
		send_point(make_point(1000, -2000, 65535, 1));
		send_point(make_point(-1, -1, 12345, 1));
		send_point(make_point(32767, -32768, 65535, 1));
		send_point(make_point(1, 0, 1, 0));
		send_point(make_point(-32768, 32767, 40000, 1));
		hold_until_drained();

		// random: mostly paths ending in a last point, some loose points
		sent = 0;
		paused_mid = 1'b0;
		while (sent < RANDOM_POINTS) begin
			send_burst = ($urandom_range(0, 7) == 0);
			noise = ($urandom_range(0, 3) == 0);
			path_len = noise ? 1 : $urandom_range(2, 16);
			shared_angle = 1'($urandom_range(0, 1));
			path_angle = draw_angle();
			for (int k = 0; k < path_len; k++) begin
				p.point_x = draw_coord();
				p.point_y = draw_coord();
				p.turn_angle = shared_angle ? path_angle : draw_angle();
				p.last_point = noise ? 1'($urandom_range(0, 1)) : (k == path_len - 1);
				send_point(p);
			end
			sent += path_len;
			if (!paused_mid && sent >= RANDOM_POINTS / 2) begin
				paused_mid = 1'b1;
				hold_until_drained();
			end
		end

		// drain and verdict
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
sv/prot_pkg.sv
sv/point_rotate_unit.sv
sim/rotation_checker.sv
sim/testbench.sv
